>>> sv/tss_pkg.sv
package tss_pkg;

  // Frame layout
  localparam int unsigned FRAME_SLOTS       = 10;
  localparam int unsigned LAST_BLOCKED_SLOT = 8;
  localparam int unsigned LAST_DYN_SLOT     = 4;
  localparam int unsigned VOICE_SLOT        = 1;

  // Slot counter modulo ten by reciprocal multiply: q = (x * 52429) >> 19 for 16-bit x.
  localparam int unsigned COUNT_W      = 16;
  localparam int unsigned DIV10_MUL    = 52429;
  localparam int unsigned DIV10_SHIFT  = 19;
  localparam int unsigned PROD_W       = 32;
  localparam int unsigned QUO_W        = PROD_W - DIV10_SHIFT;

  // Voice tag queue geometry
  localparam int unsigned VOICE_DEPTH = 16;
  localparam int unsigned VIDX_W      = $clog2(VOICE_DEPTH + 1);
  localparam int unsigned VADDR_W     = (VOICE_DEPTH > 1) ? $clog2(VOICE_DEPTH) : 1;
  localparam int unsigned TAG_W       = 8;
  localparam int unsigned SLOT_W      = 4;

  // Command codes
  localparam logic [2:0] CMD_TICK    = 3'd0;
  localparam logic [2:0] CMD_PTT     = 3'd1;
  localparam logic [2:0] CMD_CONFIRM = 3'd2;
  localparam logic [2:0] CMD_END     = 3'd3;
  localparam logic [2:0] CMD_ENQUEUE = 3'd4;

  // Grant codes
  localparam logic [2:0] GRANT_NONE    = 3'd0;
  localparam logic [2:0] GRANT_VOICE   = 3'd1;
  localparam logic [2:0] GRANT_PRIO0   = 3'd2;
  localparam logic [2:0] GRANT_PRIO1   = 3'd3;
  localparam logic [2:0] GRANT_PRIO2   = 3'd4;
  localparam logic [2:0] GRANT_PRIO3   = 3'd5;
  localparam logic [2:0] GRANT_RELAY   = 3'd6;
  localparam logic [2:0] GRANT_CONTROL = 3'd7;

  // Status codes
  localparam logic [2:0] ST_SENT        = 3'd0;
  localparam logic [2:0] ST_IDLE        = 3'd1;
  localparam logic [2:0] ST_UNSYNCED    = 3'd2;
  localparam logic [2:0] ST_NOT_READY   = 3'd3;
  localparam logic [2:0] ST_FIRST_BLOCK = 3'd4;
  localparam logic [2:0] ST_LISTEN      = 3'd5;
  localparam logic [2:0] ST_NO_CONTROL  = 3'd6;
  localparam logic [2:0] ST_DONE        = 3'd7;

  // Reported voice call codes
  localparam logic [1:0] VS_INACTIVE  = 2'd0;
  localparam logic [1:0] VS_REQUESTED = 2'd1;
  localparam logic [1:0] VS_ACTIVE    = 2'd2;

  // Voice call state machine
  typedef enum logic [2:0] {
    CALL_INACTIVE  = 3'b001,
    CALL_REQUESTED = 3'b010,
    CALL_ACTIVE    = 3'b100
  } call_state_t;

  typedef struct packed {
    logic [2:0]        cmd;
    logic [15:0]       slot_count;
    logic              synced;
    logic              rrc_ready;
    logic [3:0]        prio_ready;
    logic              relay_ready;
    logic              control_ready;
    logic              request_ok;
    logic [TAG_W-1:0]  voice_tag;
  } item_t;

  typedef struct packed {
    logic [2:0]        grant;
    logic [2:0]        status;
    logic [SLOT_W-1:0] slot_number;
    logic [TAG_W-1:0]  voice_tag_out;
    logic [1:0]        voice_state;
    logic              accepted;
  } result_t;

  // Requests from the scheduler to the voice queue
  typedef struct packed {
    logic             push;
    logic             pop;
    logic             flush;
    logic [TAG_W-1:0] tag;
  } vq_ctrl_t;

  // Voice queue status seen by the scheduler
  typedef struct packed {
    logic             not_empty;
    logic             not_full;
    logic [TAG_W-1:0] head;
  } vq_stat_t;

endpackage

>>> sv/tss_voice_queue.sv
module tss_voice_queue (
  input  logic              clk,
  input  logic              rst,
  input  tss_pkg::vq_ctrl_t ctrl,
  output tss_pkg::vq_stat_t stat
);
  import tss_pkg::*;

  logic [VIDX_W-1:0] rd_idx;
  logic [VIDX_W-1:0] wr_idx;
  logic [VIDX_W-1:0] rd_idx_inc;
  logic [TAG_W-1:0]  store [VOICE_DEPTH];

  assign rd_idx_inc = rd_idx + VIDX_W'(1);

  // Linear queue indices; both return to zero when the queue drains or is flushed.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_idx <= '0;
      wr_idx <= '0;
    end else if (ctrl.flush) begin
      rd_idx <= '0;
      wr_idx <= '0;
    end else if (ctrl.pop) begin
      if (rd_idx_inc >= wr_idx) begin
        rd_idx <= '0;
        wr_idx <= '0;
      end else begin
        rd_idx <= rd_idx_inc;
      end
    end else if (ctrl.push) begin
      wr_idx <= wr_idx + VIDX_W'(1);
    end
  end

  // Tag storage, written at the tail.
  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      store[wr_idx[VADDR_W-1:0]] <= ctrl.tag;
    end
  end

  assign stat.not_empty = (rd_idx < wr_idx);
  assign stat.not_full  = (wr_idx < VIDX_W'(VOICE_DEPTH));
  assign stat.head      = store[rd_idx[VADDR_W-1:0]];

endmodule

>>> sv/tss_core.sv
module tss_core (
  input  logic              clk,
  input  logic              rst,
  input  logic              fire,
  input  tss_pkg::item_t    item,
  input  logic [3:0]        own_slot,
  input  tss_pkg::vq_stat_t vq_stat,
  output tss_pkg::vq_ctrl_t vq_ctrl,
  output tss_pkg::result_t  res
);
  import tss_pkg::*;

  call_state_t        call_state;
  call_state_t        call_state_next;
  logic               first_frame_done;
  logic               first_frame_done_next;

  logic [PROD_W-1:0]  prod;
  logic [QUO_W-1:0]   quo;
  logic [COUNT_W-1:0] rem;
  logic [SLOT_W-1:0]  slot;

  logic               push_c;
  logic               pop_c;
  logic               flush_c;

  // Slot number 1..10 from the running counter.
  assign prod = PROD_W'(item.slot_count) * PROD_W'(DIV10_MUL);
  assign quo  = prod[PROD_W-1:DIV10_SHIFT];
  assign rem  = item.slot_count - COUNT_W'(COUNT_W'(quo) * COUNT_W'(FRAME_SLOTS));
  assign slot = rem[SLOT_W-1:0] + SLOT_W'(1);

  // Command decode, slot typing and fixed-priority grant.
  always_comb begin
    res.grant         = GRANT_NONE;
    res.status        = ST_DONE;
    res.slot_number   = '0;
    res.voice_tag_out = '0;
    res.accepted      = 1'b0;
    call_state_next   = call_state;
    first_frame_done_next = first_frame_done;
    push_c  = 1'b0;
    pop_c   = 1'b0;
    flush_c = 1'b0;
    case (item.cmd)
      CMD_TICK: begin
        if (!item.synced) begin
          res.status = ST_UNSYNCED;
        end else if (!item.rrc_ready) begin
          res.status = ST_NOT_READY;
        end else begin
          res.slot_number = slot;
          if (!first_frame_done && slot <= SLOT_W'(LAST_BLOCKED_SLOT)) begin
            res.status = ST_FIRST_BLOCK;
          end else begin
            if (slot == SLOT_W'(FRAME_SLOTS)) begin
              first_frame_done_next = 1'b1;
            end
            res.status = ST_SENT;
            if (slot == SLOT_W'(VOICE_SLOT)) begin
              if (call_state == CALL_ACTIVE && vq_stat.not_empty) begin
                res.grant         = GRANT_VOICE;
                res.voice_tag_out = vq_stat.head;
                pop_c             = 1'b1;
              end else if (item.prio_ready[0]) begin
                res.grant = GRANT_PRIO0;
              end else begin
                res.status = ST_IDLE;
              end
            end else if (slot <= SLOT_W'(LAST_DYN_SLOT)) begin
              if (item.prio_ready[0]) begin
                res.grant = GRANT_PRIO0;
              end else if (item.prio_ready[1]) begin
                res.grant = GRANT_PRIO1;
              end else begin
                res.status = ST_IDLE;
              end
            end else if (slot <= SLOT_W'(LAST_BLOCKED_SLOT)) begin
              if (item.relay_ready) begin
                res.grant = GRANT_RELAY;
              end else if (item.prio_ready[2]) begin
                res.grant = GRANT_PRIO2;
              end else if (item.prio_ready[3]) begin
                res.grant = GRANT_PRIO3;
              end else begin
                res.status = ST_IDLE;
              end
            end else begin
              if (slot != own_slot) begin
                res.status = ST_LISTEN;
              end else if (item.control_ready) begin
                res.grant = GRANT_CONTROL;
              end else begin
                res.status = ST_NO_CONTROL;
              end
            end
          end
        end
      end
      CMD_PTT: begin
        if (call_state == CALL_INACTIVE && item.request_ok) begin
          call_state_next = CALL_REQUESTED;
          res.accepted    = 1'b1;
        end
      end
      CMD_CONFIRM: begin
        if (call_state == CALL_REQUESTED) begin
          call_state_next = CALL_ACTIVE;
        end
      end
      CMD_END: begin
        call_state_next = CALL_INACTIVE;
        flush_c         = 1'b1;
      end
      CMD_ENQUEUE: begin
        if (vq_stat.not_full) begin
          push_c       = 1'b1;
          res.accepted = 1'b1;
        end
      end
      default: begin
        res.status = ST_IDLE;
      end
    endcase

    case (call_state_next)
      CALL_REQUESTED: res.voice_state = VS_REQUESTED;
      CALL_ACTIVE:    res.voice_state = VS_ACTIVE;
      default:        res.voice_state = VS_INACTIVE;
    endcase
  end

  // Queue requests only take effect for the beat that is retired.
  assign vq_ctrl.push  = push_c & fire;
  assign vq_ctrl.pop   = pop_c & fire;
  assign vq_ctrl.flush = flush_c & fire;
  assign vq_ctrl.tag   = item.voice_tag;

  // Call state and first-frame flag advance once per retired beat.
  always_ff @(posedge clk) begin
    if (rst) begin
      call_state       <= CALL_INACTIVE;
      first_frame_done <= 1'b0;
    end else if (fire) begin
      call_state       <= call_state_next;
      first_frame_done <= first_frame_done_next;
    end
  end

endmodule

>>> sv/tdma_slot_scheduler.sv
// Slot scheduler for a ten-slot TDMA frame.
// Input channel item_valid / item_ready / item carries one beat per slot tick
// or call command; result channel result_valid / result_ready / result returns
// exactly one beat per input beat, in order. The own control slot number is
// written through cfg_we / cfg_wdata while the block is idle; the user must
// keep to this, as the block itself does not enforce it.
// Each beat is held in the input register, then the grant logic, queue and call
// state update as it moves into the result register, where result_valid rises.
// Throughput is one beat per cycle while result_ready is high; the input register
// and the result register form a two-stage pipeline, so a new beat is taken
// while a result waits.
// When the receiver holds result_ready low, the result register holds, the
// input register fills, and item_ready drops until the result is taken.
// A synchronous reset empties both pipeline stages, sets the call to inactive,
// empties the voice tag queue, restarts the first-frame block and clears the
// own control slot to none. The voice tag store is not cleared; an entry is
// only read after it was written.
module tdma_slot_scheduler (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  input  tss_pkg::item_t   item,
  output logic             result_valid,
  input  logic             result_ready,
  output tss_pkg::result_t result,
  input  logic             cfg_we,
  input  logic [3:0]       cfg_wdata
);
  import tss_pkg::*;

  logic     own_valid_unused;
  logic     stage_valid;
  item_t    stage_item;
  logic     fire;
  logic [3:0] own_control_slot;
  result_t  core_res;
  vq_ctrl_t vq_ctrl;
  vq_stat_t vq_stat;

  assign own_valid_unused = 1'b0;

  // The input stage retires into the result register when that register is free.
  assign fire       = stage_valid & (~result_valid | result_ready) & ~own_valid_unused;
  assign item_ready = ~stage_valid | fire;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      own_control_slot <= '0;
    end else if (cfg_we) begin
      own_control_slot <= cfg_wdata;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (item_ready) begin
      stage_valid <= item_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ready && item_valid) begin
      stage_item <= item;
    end
  end

  tss_core u_core (
    .clk      (clk),
    .rst      (rst),
    .fire     (fire),
    .item     (stage_item),
    .own_slot (own_control_slot),
    .vq_stat  (vq_stat),
    .vq_ctrl  (vq_ctrl),
    .res      (core_res)
  );

  tss_voice_queue u_voice_queue (
    .clk  (clk),
    .rst  (rst),
    .ctrl (vq_ctrl),
    .stat (vq_stat)
  );

  // Result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else if (fire) begin
      result_valid <= 1'b1;
    end else if (result_ready) begin
      result_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      result <= core_res;
    end
  end

endmodule
